>>> design/srt_pkg.sv
// shared constants, types and trig rom builder for the stereo ray triangulation block
`timescale 1ns / 1ps

package srt_pkg;

  // pixel index width and rom depth
  localparam int PIX_W       = 8;
  localparam int PIX_ENTRIES = 2 ** PIX_W;

  // register port
  localparam int CFG_W = 16;

  // camera geometry in degrees
  localparam int FOV_DEG  = 80;
  localparam int TILT_DEG = 15;
  localparam int OFFS_L   = (180 - FOV_DEG) / 2 - TILT_DEG;
  localparam int OFFS_R   = (180 - FOV_DEG) / 2 + TILT_DEG;

  // output format
  localparam int OUT_W       = 24;
  localparam int QUO_W       = OUT_W + 1;
  localparam int OUT_POS_LIM = 8388607;
  localparam int OUT_NEG_LIM = 8388608;

  // reset values of the registers
  localparam logic [CFG_W-1:0] SEP_RESET = 16'd13568;
  localparam logic [CFG_W-1:0] HGT_RESET = 16'd2620;

  // q30 constants for the rom builder
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef enum logic [0:0] {
    CFG_SEP = 1'b0,
    CFG_HGT = 1'b1
  } srt_cfg_e;

  // per item flags carried down the divider
  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
  } srt_flags_t;

  // sine and cosine of one pixel ray, sine in [63:32], cosine in [31:0]
  // x is the angle within its quadrant in q30 radians, quad the quadrant
  function automatic logic [63:0] srt_trig(input longint unsigned x, input longint unsigned quad,
                                           input int unsigned f);
    longint unsigned x2, t, sq, cq, tmp;
    longint          s, c, so, co;
    int              sh;
    x2    = (x * x) >> 30;
    // sine series
    t = Q30_ONE;
    for (int k = 8; k >= 1; k--) begin
      t = Q30_ONE - ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
    end
    sq = (x * t) >> 30;
    // cosine series
    t = Q30_ONE;
    for (int k = 8; k >= 2; k--) begin
      t = Q30_ONE - ((x2 * t) >> 30) / 64'((2 * k - 1) * (2 * k));
    end
    tmp = ((x2 * t) >> 30) / 64'd2;
    cq  = (tmp > Q30_ONE) ? 64'd0 : Q30_ONE - tmp;
    sh  = 30 - int'(f);
    s   = longint'((sq + (64'd1 << (sh - 1))) >> sh);
    c   = longint'((cq + (64'd1 << (sh - 1))) >> sh);
    // quadrant symmetry
    case (quad)
      64'd0:   begin so = s;  co = c;  end
      64'd1:   begin so = c;  co = -s; end
      64'd2:   begin so = -s; co = -c; end
      default: begin so = -c; co = s;  end
    endcase
    return {so[31:0], co[31:0]};
  endfunction

endpackage

>>> design/srt_if.sv
// item channel interfaces of the triangulation block
`timescale 1ns / 1ps

interface srt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;

  modport source (output valid, output left_pixel, output right_pixel, input ready);
  modport sink (input valid, input left_pixel, input right_pixel, output ready);
endinterface

interface srt_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic               pos_valid;

  modport source (output valid, output pos_x, output pos_y, output pos_valid, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_valid, output ready);
endinterface

>>> design/srt_front.sv
// front end: trig rom lookup, cross products and determinant terms
`timescale 1ns / 1ps

module srt_front
  import srt_pkg::*;
#(
  parameter int P  = 240,
  parameter int F  = 16,
  parameter int TW = F + 2,
  parameter int DW = 2 * TW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srt_in_if.sink        pix,
  input  logic          full_i,
  output logic          push_o,
  output logic [DW-1:0] d_o,
  output logic [DW-1:0] nx_o,
  output logic [DW-1:0] ny_o
);

  localparam int PW = 2 * TW;
  localparam int SW = PW + 1;
  localparam int S  = (2 * F > 32) ? 2 * F - 32 : 0;
  localparam logic [SW-1:0] HALF = (SW'(1) << S) >> 1;

  // angle steps of a full turn, a quarter and a half turn
  localparam longint unsigned FULL_U = 64'd360 * 64'(P);
  localparam longint unsigned QUAD_U = 64'd90 * 64'(P);
  localparam longint unsigned HALF_U = 64'd180 * 64'(P);

  logic signed [TW-1:0] rom_sl [PIX_ENTRIES];
  logic signed [TW-1:0] rom_cl [PIX_ENTRIES];
  logic signed [TW-1:0] rom_sr [PIX_ENTRIES];
  logic signed [TW-1:0] rom_cr [PIX_ENTRIES];

  // rom contents built at elaboration
  for (genvar g = 0; g < PIX_ENTRIES; g++) begin : g_rom
    localparam longint unsigned UL =
      (64'(OFFS_L) * 64'(P) + 64'(g) * 64'(FOV_DEG)) % FULL_U;
    localparam longint unsigned UR =
      (64'(OFFS_R) * 64'(P) + 64'(g) * 64'(FOV_DEG)) % FULL_U;
    localparam longint unsigned QL = UL / QUAD_U;
    localparam longint unsigned QR = UR / QUAD_U;
    localparam longint unsigned XL = ((UL % QUAD_U) * PI_Q30 + QUAD_U) / HALF_U;
    localparam longint unsigned XR = ((UR % QUAD_U) * PI_Q30 + QUAD_U) / HALF_U;
    localparam logic [63:0] LT = srt_trig(XL, QL, F);
    localparam logic [63:0] RT = srt_trig(XR, QR, F);
    assign rom_sl[g] = LT[32 +: TW];
    assign rom_cl[g] = LT[0 +: TW];
    assign rom_sr[g] = RT[32 +: TW];
    assign rom_cr[g] = RT[0 +: TW];
  end

  // round half away from zero, then drop the extra product bits
  function automatic logic [DW-1:0] rnd(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    logic [SW-1:0] r;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    r = (m + HALF) >> S;
    if (v[SW-1]) begin
      r = -r;
    end
    return r[DW-1:0];
  endfunction

  logic                 en;
  logic [2:0]           v_q;
  logic signed [TW-1:0] sl_q, cl_q, sr_q, cr_q;
  logic signed [PW-1:0] prc_q, pcs_q, pss_q;
  logic signed [SW-1:0] dsum, nsum, ssum;
  logic [DW-1:0]        d_q, nx_q, ny_q;

  assign en        = !v_q[2] || !full_i;
  assign pix.ready = en;
  assign push_o    = v_q[2] && !full_i;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], pix.valid};
    end
  end

  assign dsum = SW'(prc_q) - SW'(pcs_q);
  assign nsum = SW'(prc_q) + SW'(pcs_q);
  assign ssum = SW'(pss_q);

  // rom read, products and determinant terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_q  <= rom_sl[pix.left_pixel];
      cl_q  <= rom_cl[pix.left_pixel];
      sr_q  <= rom_sr[pix.right_pixel];
      cr_q  <= rom_cr[pix.right_pixel];
      prc_q <= PW'(sr_q) * PW'(cl_q);
      pcs_q <= PW'(cr_q) * PW'(sl_q);
      pss_q <= PW'(sr_q) * PW'(sl_q);
      d_q   <= rnd(dsum);
      nx_q  <= rnd(nsum);
      ny_q  <= rnd(ssum);
    end
  end

  assign d_o  = d_q;
  assign nx_o = nx_q;
  assign ny_o = ny_q;

endmodule

>>> design/srt_queue.sv
// small item queue between front and back
`timescale 1ns / 1ps

module srt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue pushed while full");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o);
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue popped while empty");

  property p_count_up;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1);
  endproperty
  a_count_up: assert property (p_count_up) else $error("queue count lost a push");

endmodule

>>> design/srt_back.sv
// back end: scaling products, pipelined rounding divider and saturation
`timescale 1ns / 1ps

module srt_back
  import srt_pkg::*;
#(
  parameter int DW = 37
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] sep_i,
  input  logic [CFG_W-1:0] hgt_i,
  input  logic             empty_i,
  input  logic [DW-1:0]    d_i,
  input  logic [DW-1:0]    nx_i,
  input  logic [DW-1:0]    ny_i,
  output logic             pop_o,
  srt_out_if.source        pos
);

  localparam int MW = DW + CFG_W + 1;
  localparam int YW = MW + 1;
  localparam int CW = DW + 32;
  localparam int QB = QUO_W;

  logic en;
  assign en    = !pos.valid || pos.ready;
  assign pop_o = en && !empty_i;

  // scaling products
  logic                 v0_q, v1_q;
  logic signed [MW-1:0] prx_q, phd_q, psy_q, prx1_q;
  logic signed [DW-1:0] d0_q, d1_q;
  logic signed [YW-1:0] ny1_q;
  logic signed [CFG_W:0] sep_s, hgt_s;

  assign sep_s = $signed({1'b0, sep_i});
  assign hgt_s = $signed({1'b0, hgt_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q  <= MW'(sep_s) * MW'($signed(nx_i));
      phd_q  <= MW'(hgt_s) * MW'($signed(d_i));
      psy_q  <= MW'(sep_s) * MW'($signed(ny_i));
      d0_q   <= $signed(d_i);
      prx1_q <= prx_q;
      ny1_q  <= YW'(phd_q) + YW'(psy_q);
      d1_q   <= d0_q;
    end
  end

  // divider stage registers, index 0 is the setup stage
  logic             v_q  [QB+1];
  logic [CW-1:0]    rx_q [QB+1];
  logic [CW-1:0]    ry_q [QB+1];
  logic [CW-1:0]    dx_q [QB+1];
  logic [CW-1:0]    dy_q [QB+1];
  logic [QB-1:0]    qx_q [QB+1];
  logic [QB-1:0]    qy_q [QB+1];
  srt_flags_t       fl_q [QB+1];

  // magnitudes and rounding offsets
  logic [CW-1:0] mag_x, mag_y, mag_d;
  assign mag_x = prx1_q[MW-1] ? CW'(-(CW'(prx1_q))) : CW'(prx1_q);
  assign mag_y = ny1_q[YW-1] ? CW'(-(CW'(ny1_q))) : CW'(ny1_q);
  assign mag_d = d1_q[DW-1] ? CW'(-(CW'(d1_q))) : CW'(d1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]       <= (mag_x << 1) + (mag_d << 3);
      dx_q[0]       <= mag_d << 4;
      ry_q[0]       <= (mag_y << 1) + (mag_d << 2);
      dy_q[0]       <= mag_d << 3;
      qx_q[0]       <= '0;
      qy_q[0]       <= '0;
      fl_q[0].zero  <= d1_q == '0;
      fl_q[0].neg_x <= prx1_q[MW-1] ^ d1_q[DW-1];
      fl_q[0].neg_y <= ny1_q[YW-1] ^ d1_q[DW-1];
    end
  end

  // control valids of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en) begin
      v0_q   <= !empty_i;
      v1_q   <= v0_q;
      v_q[0] <= v1_q;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int SH = QB - j;
    logic [CW-1:0] sx, sy;
    logic          gx, gy;
    assign sx = dx_q[j-1] << SH;
    assign sy = dy_q[j-1] << SH;
    assign gx = rx_q[j-1] >= sx;
    assign gy = ry_q[j-1] >= sy;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[j] <= gx ? rx_q[j-1] - sx : rx_q[j-1];
        ry_q[j] <= gy ? ry_q[j-1] - sy : ry_q[j-1];
        dx_q[j] <= dx_q[j-1];
        dy_q[j] <= dy_q[j-1];
        qx_q[j] <= qx_q[j-1] | (QB'(gx) << SH);
        qy_q[j] <= qy_q[j-1] | (QB'(gy) << SH);
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  // sign and saturation of one quotient
  function automatic logic [OUT_W:0] sat(input logic [QB-1:0] q, input logic neg);
    logic [OUT_W-1:0] val;
    logic             bad;
    bad = 1'b0;
    if (neg) begin
      if (q > QB'(OUT_NEG_LIM)) begin
        bad = 1'b1;
        val = OUT_W'(-OUT_NEG_LIM);
      end else begin
        val = OUT_W'(-q);
      end
    end else begin
      if (q > QB'(OUT_POS_LIM)) begin
        bad = 1'b1;
        val = OUT_W'(OUT_POS_LIM);
      end else begin
        val = OUT_W'(q);
      end
    end
    return {bad, val};
  endfunction

  logic [OUT_W:0] sx_res, sy_res;
  assign sx_res = sat(qx_q[QB], fl_q[QB].neg_x);
  assign sy_res = sat(qy_q[QB], fl_q[QB].neg_y);

  // output register
  logic                    out_v_q;
  logic signed [OUT_W-1:0] px_q, py_q;
  logic                    ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fl_q[QB].zero) begin
        px_q <= '0;
        py_q <= '0;
        ok_q <= 1'b0;
      end else begin
        px_q <= $signed(sx_res[OUT_W-1:0]);
        py_q <= $signed(sy_res[OUT_W-1:0]);
        ok_q <= !sx_res[OUT_W] && !sy_res[OUT_W];
      end
    end
  end

  assign pos.valid     = out_v_q;
  assign pos.pos_x     = px_q;
  assign pos.pos_y     = py_q;
  assign pos.pos_valid = ok_q;

  property p_pop_moves;
    @(posedge clk_i) disable iff (!rst_ni) pop_o |=> v0_q;
  endproperty
  a_pop_moves: assert property (p_pop_moves) else $error("popped item lost at entry");

  property p_zero_invalid;
    @(posedge clk_i) disable iff (!rst_ni)
      (en && v_q[QB] && fl_q[QB].zero) |=> (!ok_q && px_q == '0 && py_q == '0);
  endproperty
  a_zero_invalid: assert property (p_zero_invalid) else $error("parallel rays reported");

  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni) !en |=> (v_q[QB] == $past(v_q[QB]));
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("divider moved during stall");

endmodule

>>> design/stereo_ray_triangulation.sv
// top level of the stereo ray triangulation block
`timescale 1ns / 1ps

// Stereo ray triangulation.
// pix_i takes one item per cycle: the left and right camera pixel indices.
// pos_o returns one item for each: the rays' intersection x and y in
// 1/256 inch, saturated to 24 bits, and pos_valid, low for parallel rays
// or a saturated coordinate.
// Registers camera_separation (index 0) and camera_height (index 1) are
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them
// only while no item is in flight, the block does not enforce it.
// Throughput is one item per cycle while pos_o does not stall. An item passes
// 3 front stages (rom, products, rounding), the item queue, 3 scaling stages,
// 25 divider stages (one quotient bit each) and the output register to pos_o.
// When pos_o stalls the back end holds; the 4-entry queue and the front
// pipeline keep accepting until they fill, then pix_i.ready drops.
// Reset empties all stages and the queue and loads separation 13568 and
// height 2620; the trig roms are constant and need no fill.

module stereo_ray_triangulation
  import srt_pkg::*;
#(
  parameter int PIXEL_COUNT        = 240,
  parameter int TRIG_FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  srt_in_if.sink           pix_i,
  srt_out_if.source        pos_o
);

  localparam int TW = TRIG_FRACTION_BITS + 2;
  localparam int S  = (2 * TRIG_FRACTION_BITS > 32) ? 2 * TRIG_FRACTION_BITS - 32 : 0;
  localparam int DW = 2 * TW + 1 - S;
  localparam int QDEPTH = 4;

  // configuration registers
  logic [CFG_W-1:0] sep_q, hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
      hgt_q <= HGT_RESET;
    end else if (cfg_we_i) begin
      unique case (srt_cfg_e'(cfg_idx_i))
        CFG_SEP: sep_q <= cfg_data_i;
        CFG_HGT: hgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          push, full, pop, empty;
  logic [DW-1:0] fd, fnx, fny;
  logic [DW-1:0] bd, bnx, bny;

  srt_front #(
    .P  (PIXEL_COUNT),
    .F  (TRIG_FRACTION_BITS),
    .TW (TW),
    .DW (DW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix    (pix_i),
    .full_i (full),
    .push_o (push),
    .d_o    (fd),
    .nx_o   (fnx),
    .ny_o   (fny)
  );

  srt_queue #(
    .W     (3 * DW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({fd, fnx, fny}),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  ({bd, bnx, bny})
  );

  srt_back #(
    .DW (DW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sep_i   (sep_q),
    .hgt_i   (hgt_q),
    .empty_i (empty),
    .d_i     (bd),
    .nx_i    (bnx),
    .ny_i    (bny),
    .pop_o   (pop),
    .pos     (pos_o)
  );

endmodule

>>> dv/tb_stereo_ray_triangulation.sv
// testbench for the stereo ray triangulation block: own position predictor and result checks
`timescale 1ns / 1ps

module tb_stereo_ray_triangulation;
  import srt_pkg::*;

  localparam int           PIX_COUNT   = 240;
  localparam int           TRIG_FRAC   = 16;
  localparam int           LATENCY     = 32;
  localparam int           SETTLE_CYC  = LATENCY + 8;
  localparam int           LONG_HOLD   = 400;
  localparam longint       CYCLE_LIMIT = 400000;
  localparam longint       POS_MAX     = 64'sd8388607;
  localparam longint       POS_MIN     = -64'sd8388608;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               ok;
  } position_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  srt_in_if  pix_if ();
  srt_out_if pos_if ();

  stereo_ray_triangulation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .pos_o      (pos_if)
  );

  // local copy of the geometry registers
  logic [15:0] sep_reg;
  logic [15:0] hgt_reg;

  position_t   pending_pos[$];
  int          error_cnt;
  int          sent_cnt;
  int          recv_cnt;
  int          parallel_cnt;
  int          sat_cnt;
  longint      cycle_cnt = 0;
  bit          hold_toggle;
  bit          hold_ack;
  int          hold_left;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // sine and cosine of one ray in q16, angle in 1/PIX_COUNT degree steps
  function automatic void ray_trig(input longint unsigned pixel, input longint unsigned offs,
                                   output longint s_o, output longint c_o);
    longint unsigned units, quad, rem, x, x2, t, sq, cq, tmp;
    longint          s, c;
    int              sh;
    units = (offs * PIX_COUNT + pixel * FOV_DEG) % (360 * PIX_COUNT);
    quad  = units / (90 * PIX_COUNT);
    rem   = units % (90 * PIX_COUNT);
    x     = (rem * PI_Q30 + 90 * PIX_COUNT) / (180 * PIX_COUNT);
    x2    = (x * x) >> 30;
    t = Q30_ONE;
    for (int k = 8; k >= 1; k--) begin
      t = Q30_ONE - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
    end
    sq = (x * t) >> 30;
    t = Q30_ONE;
    for (int k = 8; k >= 2; k--) begin
      t = Q30_ONE - ((x2 * t) >> 30) / longint'((2 * k - 1) * (2 * k));
    end
    tmp = ((x2 * t) >> 30) / 2;
    cq  = (tmp > Q30_ONE) ? 0 : Q30_ONE - tmp;
    sh  = 30 - TRIG_FRAC;
    s   = longint'((sq + (64'd1 << (sh - 1))) >> sh);
    c   = longint'((cq + (64'd1 << (sh - 1))) >> sh);
    case (quad)
      0: begin s_o = s;  c_o = c;  end
      1: begin s_o = c;  c_o = -s; end
      2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  // quotient rounded half away from zero
  function automatic longint round_div(input longint n, input longint d);
    longint unsigned mn, md, q;
    bit              neg;
    neg = (n < 0) != (d < 0);
    mn  = (n < 0) ? -n : n;
    md  = (d < 0) ? -d : d;
    q   = (2 * mn + md) / (2 * md);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_pos(input longint v, inout logic ok);
    if (v > POS_MAX) begin
      ok = 1'b0;
      return POS_MAX;
    end
    if (v < POS_MIN) begin
      ok = 1'b0;
      return POS_MIN;
    end
    return v;
  endfunction

  // intersection point of the two rays for the current geometry
  function automatic position_t intersect_rays(input logic [7:0] lp, input logic [7:0] rp);
    longint    sl, cl, sr, cr, det, nx, ny, px, py;
    logic      ok;
    position_t res;
    ray_trig(lp, OFFS_L, sl, cl);
    ray_trig(rp, OFFS_R, sr, cr);
    // 2F is 32, so the products need no rescale
    det = sr * cl - cr * sl;
    nx  = sr * cl + cr * sl;
    ny  = sr * sl;
    ok  = 1'b1;
    if (det == 0) begin
      res.x  = '0;
      res.y  = '0;
      res.ok = 1'b0;
      return res;
    end
    px = clamp_pos(round_div(longint'(sep_reg) * nx, 8 * det), ok);
    py = clamp_pos(round_div(longint'(hgt_reg) * det + longint'(sep_reg) * ny, 4 * det), ok);
    res.x  = px[23:0];
    res.y  = py[23:0];
    res.ok = ok;
    return res;
  endfunction

  // send one item and hold valid high on return
  task automatic send_item(input logic [7:0] lp, input logic [7:0] rp);
    position_t p;
    pix_if.valid       <= 1'b1;
    pix_if.left_pixel  <= lp;
    pix_if.right_pixel <= rp;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    p = intersect_rays(lp, rp);
    if (!p.ok) begin
      if (p.x == 0 && p.y == 0) parallel_cnt++;
      else sat_cnt++;
    end
    pending_pos.push_back(p);
    sent_cnt++;
  endtask

  task automatic pause_input(input int n);
    pix_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait for every expected item, then let the pipeline settle
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input srt_cfg_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SEP) sep_reg = val;
    else hgt_reg = val;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [15:0] sep, input logic [15:0] hgt);
    drain();
    write_reg(CFG_SEP, sep);
    write_reg(CFG_HGT, hgt);
  endtask

  // random pixel pair, biased toward parallel and near parallel rays
  task automatic random_pair(output logic [7:0] lp, output logic [7:0] rp);
    int sel;
    sel = $urandom_range(0, 9);
    rp  = 8'($urandom_range(0, 255));
    if (sel == 0) begin
      rp = 8'($urandom_range(0, 165));
      lp = rp + 8'd90;
    end else if (sel <= 2) begin
      rp = 8'($urandom_range(3, 162));
      lp = rp + 8'd90 + 8'($urandom_range(0, 6)) - 8'd3;
    end else begin
      lp = 8'($urandom_range(0, 255));
    end
  endtask

  // random items in bursts with random gaps
  task automatic run_random(input int n);
    logic [7:0] lp, rp;
    int         burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      random_pair(lp, rp);
      send_item(lp, rp);
      burst--;
      if (burst == 0) begin
        pause_input($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  // field extremes at reset geometry
  task automatic test_reset_corners();
    send_item(8'd0, 8'd0);
    send_item(8'd0, 8'd255);
    send_item(8'd255, 8'd0);
    send_item(8'd255, 8'd255);
    send_item(8'd239, 8'd239);
    send_item(8'd120, 8'd120);
    send_item(8'd170, 8'd85);
    send_item(8'd1, 8'd254);
  endtask

  // identical ray angles give no intersection; the last pair is one pixel off parallel
  task automatic test_parallel_rays();
    send_item(8'd90, 8'd0);
    send_item(8'd200, 8'd110);
    send_item(8'd255, 8'd165);
    send_item(8'd91, 8'd0);
  endtask

  // register extremes with a few directed items each
  task automatic test_geometry_extremes();
    set_geometry(16'd0, 16'd0);
    send_item(8'd0, 8'd255);
    send_item(8'd120, 8'd120);
    set_geometry(16'hFFFF, 16'hFFFF);
    send_item(8'd0, 8'd255);
    send_item(8'd89, 8'd0);
    send_item(8'd120, 8'd120);
    set_geometry(16'hFFFF, 16'd0);
    send_item(8'd240, 8'd10);
    set_geometry(16'd0, 16'hFFFF);
    send_item(8'd60, 8'd200);
  endtask

  // random items over several geometries
  task automatic test_random_geometry();
    set_geometry(SEP_RESET, HGT_RESET);
    run_random(250);
    set_geometry(16'hFFFF, 16'hFFFF);
    run_random(200);
    set_geometry(16'd0, 16'd0);
    run_random(150);
    for (int i = 0; i < 3; i++) begin
      set_geometry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_random(200);
    end
  endtask

  // long output stall while input keeps offering, then a full drain pause and more random items
  task automatic test_backpressure();
    logic [7:0] lp, rp;
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 120; i++) begin
      random_pair(lp, rp);
      send_item(lp, rp);
    end
    pause_input(1);
    while (pending_pos.size() != 0) @(posedge clk_i);
    run_random(120);
  endtask

  // output side: stall pattern, long hold and result check
  always @(posedge clk_i) begin
    position_t exp_pos;
    if (!rst_ni) begin
      pos_if.ready <= 1'b0;
      hold_ack     = hold_toggle;
      hold_left    = 0;
    end else begin
      if (pos_if.valid && pos_if.ready) begin
        recv_cnt++;
        if (pending_pos.size() == 0) begin
          $error("unexpected item x=%0d y=%0d", pos_if.pos_x, pos_if.pos_y);
          error_cnt++;
        end else begin
          exp_pos = pending_pos.pop_front();
          if (pos_if.pos_x !== exp_pos.x) begin
            $error("pos_x expected %0d got %0d", exp_pos.x, pos_if.pos_x);
            error_cnt++;
          end
          if (pos_if.pos_y !== exp_pos.y) begin
            $error("pos_y expected %0d got %0d", exp_pos.y, pos_if.pos_y);
            error_cnt++;
          end
          if (pos_if.pos_valid !== exp_pos.ok) begin
            $error("pos_valid expected %0b got %0b", exp_pos.ok, pos_if.pos_valid);
            error_cnt++;
          end
        end
      end
      if (hold_ack != hold_toggle) begin
        hold_ack  = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pos_if.ready <= 1'b0;
      end else begin
        // stall modes step through always ready, mostly ready, periodic and half random
        case ((cycle_cnt / 256) % 4)
          0: pos_if.ready <= 1'b1;
          1: pos_if.ready <= ($urandom_range(0, 3) != 0);
          2: pos_if.ready <= (cycle_cnt % 5 < 2);
          default: pos_if.ready <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_SEP;
    cfg_data_i         <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.left_pixel  <= '0;
    pix_if.right_pixel <= '0;
    sep_reg      = SEP_RESET;
    hgt_reg      = HGT_RESET;
    error_cnt    = 0;
    sent_cnt     = 0;
    recv_cnt     = 0;
    parallel_cnt = 0;
    sat_cnt      = 0;
    hold_toggle  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_corners();
    test_parallel_rays();
    test_geometry_extremes();
    test_random_geometry();
    test_backpressure();
    drain();

    $display("sent %0d pixel pairs, checked %0d positions over several geometries",
             sent_cnt, recv_cnt);
    $display("%0d parallel and %0d saturated cases seen", parallel_cnt, sat_cnt);
    if (error_cnt == 0 && pending_pos.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
